// ===== design/lcdcs_pkg.sv =====
// Package for the character LCD command sequencer.
// Holds operation codes, register indexes, field widths and command constants.
// No dependencies.
`default_nettype none
package lcdcs_pkg;

    localparam int NUM_W  = 32;
    localparam int CIDX_W = 3;
    localparam int CDAT_W = 8;

    typedef enum logic [3:0] {
        OP_INIT   = 4'd0,
        OP_CHAR   = 4'd1,
        OP_POS    = 4'd2,
        OP_CLEAR  = 4'd3,
        OP_CLRHOM = 4'd4,
        OP_DEC    = 4'd5,
        OP_DISP   = 4'd6,
        OP_CURS   = 4'd7,
        OP_BLINK  = 4'd8,
        OP_BLIGHT = 4'd9
    } t_op;

    typedef enum logic [CIDX_W-1:0] {
        REG_BUS8   = 3'd0,
        REG_LINES  = 3'd1,
        REG_COLS   = 3'd2,
        REG_BL_LOW = 3'd3
    } t_reg_idx;

    localparam logic [7:0] CMD_CLEAR  = 8'h01;
    localparam logic [7:0] CMD_HOME   = 8'h02;
    localparam logic [7:0] CMD_ENTRY  = 8'h06;
    localparam logic [7:0] CMD_DISP   = 8'h08;
    localparam logic [7:0] CMD_SHIFT  = 8'h17;
    localparam logic [7:0] CMD_FUNC   = 8'h20;
    localparam logic [7:0] FUNC_8BIT  = 8'h10;
    localparam logic [7:0] FUNC_2LINE = 8'h08;
    localparam logic [7:0] CMD_DDRAM  = 8'h80;
    localparam logic [7:0] ROW_1_OFS  = 8'h40;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] WAKE_8     = 8'h30;
    localparam logic [7:0] WAKE_4     = 8'h03;
    localparam logic [7:0] GO_4BIT    = 8'h02;
    localparam logic [2:0] FLAG_DISP  = 3'b100;
    localparam logic [2:0] FLAG_CURS  = 3'b010;
    localparam logic [2:0] FLAG_BLINK = 3'b001;

    localparam logic [13:0] T_POWER_UP = 14'd15000;
    localparam logic [13:0] T_BYTE     = 14'd1000;
    localparam logic [12:0] T_WAKE     = 13'd5000;
    localparam logic [12:0] T_GO       = 13'd5;
    localparam logic [12:0] T_CLEAR    = 13'd7000;

    localparam logic [3:0] INIT_LAST = 4'd9;

endpackage
`default_nettype wire

// ===== design/lcdcs_ifs.sv =====
// Channel interfaces of the LCD command sequencer: request, result, config write.
// No dependencies.
`default_nettype none
interface lcdcs_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  operation;
    logic [7:0]  char_code;
    logic [1:0]  line_index;
    logic [5:0]  column_index;
    logic [31:0] number;
    logic        switch_on;
    modport source (output valid, operation, char_code, line_index, column_index,
                    number, switch_on, input ready);
    modport sink   (input valid, operation, char_code, line_index, column_index,
                    number, switch_on, output ready);
endinterface

interface lcdcs_res_if;
    logic        valid;
    logic        ready;
    logic        strobe_valid;
    logic        reg_select;
    logic [7:0]  bus_value;
    logic [13:0] wait_before_us;
    logic [12:0] wait_after_us;
    logic        backlight_pin;
    logic        last_of_run;
    modport source (output valid, strobe_valid, reg_select, bus_value, wait_before_us,
                    wait_after_us, backlight_pin, last_of_run, input ready);
    modport sink   (input valid, strobe_valid, reg_select, bus_value, wait_before_us,
                    wait_after_us, backlight_pin, last_of_run, output ready);
endinterface

interface lcdcs_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/character_lcd_command_sequencer.sv =====
// Character LCD command sequencer: one request in, a run of results (enable strobes or a backlight update) out.
// The first result is loaded from the send state once the output register is free; a decimal
// print first produces its digits one by one in the divide-by-ten unit.
// Further results follow at one per cycle unless the output stalls; the request
// side is ready again once the last is loaded.
// Reset (synchronous, active low) restores register defaults, clears flags and backlight.
`default_nettype none
module character_lcd_command_sequencer
    import lcdcs_pkg::*;
#(
    parameter int MAX_DIGITS = 10
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    lcdcs_req_if.sink    i_req,
    lcdcs_res_if.source  o_res,
    lcdcs_cfg_if.sink    i_cfg
);
    localparam int K_W = $clog2(MAX_DIGITS + 1);
    localparam int A_W = $clog2(MAX_DIGITS);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_SEND = 5'b00100,
        S_LOW  = 5'b01000,
        S_HOLD = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // configuration and persistent state
    logic       r_bus8, r_bl_low, r_bl_on;
    logic [2:0] r_lines, r_flags;
    logic [5:0] r_cols;

    // captured request
    t_op        r_op;
    logic [7:0] r_ch;
    logic [1:0] r_line;
    logic [5:0] r_col;
    logic [3:0] r_step;
    logic [K_W-1:0] r_k;
    logic [3:0] r_stack [MAX_DIGITS];

    // output register
    logic        r_ov, r_sv, r_rs, r_pin, r_last;
    logic [7:0]  r_bus;
    logic [13:0] r_bef;
    logic [12:0] r_aft;

    logic        w_acc, w_free, w_div_start, w_div_done, w_more;
    logic [NUM_W-1:0] w_div_in, w_quot;
    logic [3:0]  w_rem;
    logic [2:0]  w_newflags;

    // current byte descriptor
    logic        d_raw, d_sv, d_rs, d_last;
    logic [7:0]  d_byte, d_addr;
    logic [13:0] d_bef;
    logic [12:0] d_aft;

    assign w_acc  = i_req.valid && i_req.ready;
    assign w_free = !r_ov || o_res.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    lcdcs_div10 u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_in),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // another digit follows while quotient is nonzero and stack has room
    assign w_more      = (w_quot != '0) && ((r_k + 1'b1) < K_W'(MAX_DIGITS));
    assign w_div_start = (w_acc && i_req.operation == OP_DEC)
                      || (r_state == S_DIV && w_div_done && w_more);
    assign w_div_in    = (r_state == S_IDLE) ? i_req.number : w_quot;

    // flag update for switch and init requests
    always_comb begin
        case (i_req.operation)
            OP_DISP:  w_newflags = i_req.switch_on ? (r_flags | FLAG_DISP)
                                                   : (r_flags & ~FLAG_DISP);
            OP_CURS:  w_newflags = i_req.switch_on ? (r_flags | FLAG_CURS)
                                                   : (r_flags & ~FLAG_CURS);
            OP_BLINK: w_newflags = i_req.switch_on ? (r_flags | FLAG_BLINK)
                                                   : (r_flags & ~FLAG_BLINK);
            OP_INIT:  w_newflags = FLAG_DISP;
            default:  w_newflags = r_flags;
        endcase
    end

    // set-position address, wrapped to a byte
    always_comb begin
        d_addr = CMD_DDRAM | {2'b00, r_col};
        if (r_line == 2'd1) begin
            d_addr = d_addr + ROW_1_OFS;
        end else if (r_line == 2'd2 && r_lines > 3'd2) begin
            d_addr = d_addr + {2'b00, r_cols};
        end else if (r_line == 2'd3 && r_lines > 3'd2) begin
            d_addr = d_addr + ROW_1_OFS + {2'b00, r_cols};
        end
    end

    // byte descriptor for the current step
    always_comb begin
        d_raw  = 1'b0;
        d_sv   = 1'b1;
        d_rs   = 1'b0;
        d_last = 1'b1;
        d_byte = '0;
        d_bef  = T_BYTE;
        d_aft  = '0;
        case (r_op)
            OP_INIT: begin
                d_last = (r_step == INIT_LAST);
                case (r_step) inside
                    4'd0, 4'd1, 4'd2: begin
                        d_raw  = 1'b1;
                        d_byte = r_bus8 ? WAKE_8 : WAKE_4;
                        d_bef  = (r_step == 4'd0) ? T_POWER_UP : '0;
                        d_aft  = T_WAKE;
                    end
                    4'd3: begin
                        d_raw  = 1'b1;
                        d_byte = r_bus8 ? WAKE_8 : GO_4BIT;
                        d_bef  = '0;
                        d_aft  = T_GO;
                    end
                    4'd4: d_byte = CMD_FUNC | (r_bus8 ? FUNC_8BIT : 8'h00)
                                 | ((r_lines > 3'd1) ? FUNC_2LINE : 8'h00);
                    4'd5: d_byte = CMD_ENTRY;
                    4'd6: d_byte = CMD_SHIFT;
                    4'd7: d_byte = CMD_DISP | {5'd0, FLAG_DISP};
                    4'd8: begin
                        d_byte = CMD_CLEAR;
                        d_aft  = T_CLEAR;
                    end
                    default: d_byte = CMD_HOME;
                endcase
            end
            OP_CHAR: begin
                d_rs   = 1'b1;
                d_byte = r_ch;
            end
            OP_POS:  d_byte = d_addr;
            OP_CLEAR: begin
                d_byte = CMD_CLEAR;
                d_aft  = T_CLEAR;
            end
            OP_CLRHOM: begin
                d_last = (r_step != 4'd0);
                d_byte = (r_step == 4'd0) ? CMD_CLEAR : CMD_HOME;
                d_aft  = (r_step == 4'd0) ? T_CLEAR : '0;
            end
            OP_DEC: begin
                d_rs   = 1'b1;
                d_last = (r_k == K_W'(1));
                d_byte = ASCII_ZERO | {4'd0, r_stack[A_W'(r_k - 1'b1)]};
            end
            OP_BLIGHT: begin
                d_raw = 1'b1;
                d_sv  = 1'b0;
                d_bef = '0;
            end
            default: d_byte = CMD_DISP | {5'd0, r_flags};
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    unique case (i_req.operation) inside
                        OP_INIT, OP_CHAR, OP_POS, OP_CLEAR, OP_CLRHOM, OP_DISP,
                        OP_CURS, OP_BLINK, OP_BLIGHT: n_state = S_SEND;
                        OP_DEC:  n_state = S_DIV;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_DIV:  if (w_div_done && !w_more) n_state = S_SEND;
            S_SEND: begin
                if (w_free) begin
                    if (!d_raw && !r_bus8) n_state = S_LOW;
                    else if (d_last)       n_state = S_IDLE;
                end
            end
            S_LOW:  if (w_free) n_state = d_last ? S_IDLE : S_SEND;
            S_HOLD: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_bus8   <= 1'b0;
            r_lines  <= 3'd2;
            r_cols   <= 6'd16;
            r_bl_low <= 1'b0;
            r_flags  <= '0;
            r_bl_on  <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            // configuration writes
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_BUS8:   r_bus8   <= i_cfg.data[0];
                    REG_LINES:  r_lines  <= i_cfg.data[2:0];
                    REG_COLS:   r_cols   <= i_cfg.data[5:0];
                    REG_BL_LOW: r_bl_low <= i_cfg.data[0];
                    default: ;
                endcase
            end
            // request-time state updates
            if (w_acc) begin
                r_flags <= w_newflags;
                if (i_req.operation == OP_BLIGHT) r_bl_on <= i_req.switch_on;
            end
            // output register valid: a new load wins over a drain
            if ((r_state == S_SEND || r_state == S_LOW) && w_free) r_ov <= 1'b1;
            else if (o_res.ready)                                  r_ov <= 1'b0;
        end
    end

    // payload, step counter and digit stack
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_op   <= t_op'(i_req.operation);
            r_ch   <= i_req.char_code;
            r_line <= i_req.line_index;
            r_col  <= i_req.column_index;
            r_step <= '0;
            r_k    <= '0;
        end
        if (r_state == S_DIV && w_div_done) begin
            r_stack[A_W'(r_k)] <= w_rem;
            r_k <= r_k + 1'b1;
        end
        // one transfer of the current byte, or its first nibble
        if (r_state == S_SEND && w_free) begin
            r_sv   <= d_sv;
            r_rs   <= d_rs;
            r_pin  <= r_bl_on ^ r_bl_low;
            r_bef  <= d_bef;
            if (d_raw || r_bus8) begin
                r_bus  <= d_byte;
                r_aft  <= d_aft;
                r_last <= d_last;
            end else begin
                r_bus  <= {4'd0, d_byte[7:4]};
                r_aft  <= '0;
                r_last <= 1'b0;
            end
        end
        if (r_state == S_LOW && w_free) begin
            r_bus  <= {4'd0, d_byte[3:0]};
            r_bef  <= '0;
            r_aft  <= d_aft;
            r_last <= d_last;
        end
        // advance to the next byte
        if (((r_state == S_SEND && (d_raw || r_bus8)) || r_state == S_LOW) && w_free) begin
            if (r_op == OP_DEC) r_k <= r_k - 1'b1;
            else                r_step <= r_step + 1'b1;
        end
    end

    assign o_res.valid          = r_ov;
    assign o_res.strobe_valid   = r_sv;
    assign o_res.reg_select     = r_rs;
    assign o_res.bus_value      = r_bus;
    assign o_res.wait_before_us = r_bef;
    assign o_res.wait_after_us  = r_aft;
    assign o_res.backlight_pin  = r_pin;
    assign o_res.last_of_run    = r_last;
endmodule
`default_nettype wire

// ===== design/lcdcs_div10.sv =====
// Divide-by-ten unit: reciprocal multiplication, quotient and remainder valid in the cycle after start.
// Depends on lcdcs_pkg.
`default_nettype none
module lcdcs_div10
    import lcdcs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_dividend,
    output logic                  o_done,
    output logic [NUM_W-1:0]      o_quot,
    output logic [3:0]            o_rem
);
    // ceil(2^35 / 10): exact quotient for every 32-bit dividend after a 35-bit shift
    localparam logic [NUM_W-1:0] RECIP_10 = 32'hCCCCCCCD;
    localparam int               SHIFT    = 35;

    logic [2*NUM_W-1:0] w_prod;
    logic [NUM_W-1:0]   r_q;
    logic [3:0]         r_lo;
    logic               r_done;

    assign w_prod = {{NUM_W{1'b0}}, i_dividend} * {{NUM_W{1'b0}}, RECIP_10};

    // quotient and the low dividend nibble, registered on start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
        if (i_start) begin
            r_q  <= NUM_W'(w_prod[2*NUM_W-1:SHIFT]);
            r_lo <= i_dividend[3:0];
        end
    end

    // remainder fits in four bits, so n - 10q is taken modulo 16
    assign o_rem  = r_lo - {r_q[0], 3'b000} - {r_q[2:0], 1'b0};
    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire

// ===== design/lcdcs_chk.sv =====
// Port-level checks for the LCD command sequencer, bound to the top level.
// Depends on the top level's ports only.
`default_nettype none
module lcdcs_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_req_ready,
    input wire logic        i_res_valid,
    input wire logic        i_res_ready,
    input wire logic        i_strobe_valid,
    input wire logic [7:0]  i_bus_value,
    input wire logic [13:0] i_wait_before,
    input wire logic        i_last
);
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_bus_value)
            && $stable(i_last))
        else $error("stalled result changed");

    // no new request while a run is still being delivered
    a_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_last |-> !i_req_ready)
        else $error("request taken mid-run");

    // a backlight-only update is a single, empty result
    a_blight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_strobe_valid |-> i_last && i_bus_value == 8'd0)
        else $error("malformed backlight update");

    // only strobes carry a wait before
    a_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_wait_before != 14'd0 |-> i_strobe_valid)
        else $error("wait on non-strobe");
endmodule

bind character_lcd_command_sequencer lcdcs_chk u_lcdcs_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_ready    (i_req.ready),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_strobe_valid (o_res.strobe_valid),
    .i_bus_value    (o_res.bus_value),
    .i_wait_before  (o_res.wait_before_us),
    .i_last         (o_res.last_of_run)
);
`default_nettype wire

// ===== dv/lcdcs_checker.sv =====
// Result checker for the LCD command sequencer: predicts the strobe run of
// every request transfer and compares each result transfer against it.
// Depends on lcdcs_pkg and the channel interfaces in lcdcs_ifs.sv.
`timescale 1ns / 1ps
module lcdcs_checker
    import lcdcs_pkg::*;
#(
    parameter int MAX_DIGITS = 10
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lcdcs_req_if        req,
    lcdcs_res_if        res,
    lcdcs_cfg_if        cfg,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic        strobe_valid;
        logic        reg_select;
        logic [7:0]  bus_value;
        logic [13:0] wait_before_us;
        logic [12:0] wait_after_us;
        logic        backlight_pin;
        logic        last_of_run;
    } t_strobe;

    t_strobe    strobe_q[$];
    logic       bus8;
    logic [2:0] lines;
    logic [5:0] cols;
    logic       bl_low;
    logic [2:0] flags;
    logic       bl_on;
    int         errors;
    int         pend = 0;

    assign o_errors  = errors;
    assign o_pending = pend;

    function automatic void push_strobe(logic sv, logic rs, logic [7:0] bus,
                                        logic [13:0] wb, logic [12:0] wa);
        t_strobe s;
        s.strobe_valid   = sv;
        s.reg_select     = rs;
        s.bus_value      = bus;
        s.wait_before_us = wb;
        s.wait_after_us  = wa;
        s.backlight_pin  = bl_on ^ bl_low;
        s.last_of_run    = 1'b0;
        strobe_q.push_back(s);
    endfunction

    // one byte: single strobe on an 8-bit bus, two nibbles otherwise
    function automatic void push_byte(logic rs, logic [7:0] b, logic [12:0] wa);
        if (bus8) begin
            push_strobe(1'b1, rs, b, T_BYTE, wa);
        end else begin
            push_strobe(1'b1, rs, {4'h0, b[7:4]}, T_BYTE, 13'd0);
            push_strobe(1'b1, rs, {4'h0, b[3:0]}, 14'd0, wa);
        end
    endfunction

    function automatic void predict_run(logic [3:0] op, logic [7:0] ch, logic [1:0] ln,
                                        logic [5:0] col, logic [31:0] num, logic on);
        int          before_n;
        int          k;
        logic [7:0]  addr;
        logic [3:0]  digits[MAX_DIGITS];
        logic [31:0] v;
        logic [2:0]  bitsel;
        t_strobe     s;
        before_n = strobe_q.size();
        case (op) inside
            OP_INIT: begin
                for (k = 0; k < 3; k++)
                    push_strobe(1'b1, 1'b0, bus8 ? WAKE_8 : WAKE_4,
                                k == 0 ? T_POWER_UP : 14'd0, T_WAKE);
                push_strobe(1'b1, 1'b0, bus8 ? WAKE_8 : GO_4BIT, 14'd0, T_GO);
                push_byte(1'b0, CMD_FUNC | (bus8 ? FUNC_8BIT : 8'h0)
                          | (lines > 1 ? FUNC_2LINE : 8'h0), 13'd0);
                push_byte(1'b0, CMD_ENTRY, 13'd0);
                push_byte(1'b0, CMD_SHIFT, 13'd0);
                flags = FLAG_DISP;
                push_byte(1'b0, CMD_DISP | {5'd0, flags}, 13'd0);
                push_byte(1'b0, CMD_CLEAR, T_CLEAR);
                push_byte(1'b0, CMD_HOME, 13'd0);
            end
            OP_CHAR: push_byte(1'b1, ch, 13'd0);
            OP_POS: begin
                addr = CMD_DDRAM | {2'b00, col};
                if (ln == 2'd1) addr = addr + ROW_1_OFS;
                else if (ln == 2'd2 && lines > 2) addr = addr + {2'b00, cols};
                else if (ln == 2'd3 && lines > 2) addr = addr + ROW_1_OFS + {2'b00, cols};
                push_byte(1'b0, addr, 13'd0);
            end
            OP_CLEAR: push_byte(1'b0, CMD_CLEAR, T_CLEAR);
            OP_CLRHOM: begin
                push_byte(1'b0, CMD_CLEAR, T_CLEAR);
                push_byte(1'b0, CMD_HOME, 13'd0);
            end
            OP_DEC: begin
                v = num;
                k = 0;
                do begin
                    digits[k] = 4'(v % 10);
                    v = v / 10;
                    k++;
                end while (v != 0 && k < MAX_DIGITS);
                while (k > 0) begin
                    k--;
                    push_byte(1'b1, ASCII_ZERO + {4'h0, digits[k]}, 13'd0);
                end
            end
            OP_DISP, OP_CURS, OP_BLINK: begin
                bitsel = (op == OP_DISP) ? FLAG_DISP : (op == OP_CURS) ? FLAG_CURS : FLAG_BLINK;
                flags = on ? (flags | bitsel) : (flags & ~bitsel);
                push_byte(1'b0, CMD_DISP | {5'd0, flags}, 13'd0);
            end
            OP_BLIGHT: begin
                bl_on = on;
                push_strobe(1'b0, 1'b0, 8'h0, 14'd0, 13'd0);
            end
            default: ;
        endcase
        if (strobe_q.size() > before_n) begin
            s = strobe_q.pop_back();
            s.last_of_run = 1'b1;
            strobe_q.push_back(s);
        end
    endfunction

    // watch all three channels at each rising edge
    always @(posedge i_clk) begin
        t_strobe got, want;
        if (!i_rst_n) begin
            bus8   = 1'b0;
            lines  = 3'd2;
            cols   = 6'd16;
            bl_low = 1'b0;
            flags  = 3'd0;
            bl_on  = 1'b0;
            errors = 0;
            strobe_q.delete();
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (t_reg_idx'(cfg.index))
                    REG_BUS8:   bus8   = cfg.data[0];
                    REG_LINES:  lines  = cfg.data[2:0];
                    REG_COLS:   cols   = cfg.data[5:0];
                    REG_BL_LOW: bl_low = cfg.data[0];
                    default: ;
                endcase
            end
            if (res.valid && res.ready) begin
                got = {res.strobe_valid, res.reg_select, res.bus_value, res.wait_before_us,
                       res.wait_after_us, res.backlight_pin, res.last_of_run};
                if (strobe_q.size() == 0) begin
                    $display("%t: unexpected result transfer %h", $time, got);
                    errors = errors + 1;
                end else begin
                    want = strobe_q.pop_front();
                    if (got !== want) begin
                        $display("%t: result mismatch expected sv=%b rs=%b bus=%h",
                                 $time, want.strobe_valid, want.reg_select,
                                 want.bus_value,
                                 "  wb=%0d wa=%0d bl=%b last=%b",
                                 want.wait_before_us, want.wait_after_us,
                                 want.backlight_pin, want.last_of_run);
                        $display("%t:                 actual   sv=%b rs=%b bus=%h",
                                 $time, got.strobe_valid, got.reg_select,
                                 got.bus_value,
                                 "  wb=%0d wa=%0d bl=%b last=%b",
                                 got.wait_before_us, got.wait_after_us,
                                 got.backlight_pin, got.last_of_run);
                        errors = errors + 1;
                    end
                end
            end
            if (req.valid && req.ready)
                predict_run(req.operation, req.char_code, req.line_index, req.column_index,
                            req.number, req.switch_on);
        end
        pend = strobe_q.size();
    end

endmodule

// ===== dv/character_lcd_command_sequencer_test.sv =====
// Testbench top for the LCD command sequencer: clock, reset, request and
// configuration stimulus, result back-pressure and the verdict.
// Depends on lcdcs_pkg, lcdcs_ifs.sv, lcdcs_checker and the sequencer RTL.
`timescale 1ns / 1ps
module character_lcd_command_sequencer_test;
    import lcdcs_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int MAX_DIGITS = 10;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors;
    int   pending;
    int   idle_cycles;
    int   stall_mode;
    int   stall_phase;

    lcdcs_req_if req ();
    lcdcs_res_if res ();
    lcdcs_cfg_if cfg ();

    character_lcd_command_sequencer #(
        .MAX_DIGITS (MAX_DIGITS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req.sink),
        .o_res   (res.source),
        .i_cfg   (cfg.sink)
    );

    lcdcs_checker #(
        .MAX_DIGITS (MAX_DIGITS)
    ) chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .req       (req),
        .res       (res),
        .cfg       (cfg),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver stall pattern: modes change every so often, one of them never stalls
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase % 97 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: res.ready <= 1'b1;
            1: res.ready <= ($urandom_range(0, 3) != 0);
            2: res.ready <= (stall_phase % 7 < 3);
            default: res.ready <= ($urandom_range(0, 1) != 0);
        endcase
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((req.valid && req.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("character_lcd_command_sequencer_test: done, errors");
            $finish;
        end
    end

    // valid stays high after the transfer; stop_config drops it at the end of a group
    task automatic write_reg(t_reg_idx idx, logic [7:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge i_clk); while (!cfg.ready);
    endtask

    task automatic stop_config();
        cfg.valid <= 1'b0;
    endtask

    task automatic stop_requests();
        req.valid <= 1'b0;
    endtask

    task automatic settle();
        do @(posedge i_clk); while (pending != 0 || req.valid);
        repeat (80) @(posedge i_clk);
    endtask

    int burst_left = 0;

    // valid drops only for a gap between bursts, or through stop_requests
    task automatic send_request(logic [3:0] op, logic [7:0] ch, logic [1:0] ln,
                                logic [5:0] col, logic [31:0] num, logic on);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            if ($urandom_range(0, 2) != 0) begin
                req.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        burst_left--;
        req.valid        <= 1'b1;
        req.operation    <= op;
        req.char_code    <= ch;
        req.line_index   <= ln;
        req.column_index <= col;
        req.number       <= num;
        req.switch_on    <= on;
        do @(posedge i_clk); while (!req.ready);
    endtask

    task automatic random_request();
        logic [31:0] num;
        case ($urandom_range(0, 3))
            0: num = $urandom_range(0, 9);
            1: num = $urandom_range(0, 99999);
            default: num = $urandom;
        endcase
        send_request(4'($urandom_range(0, 15)), 8'($urandom), 2'($urandom),
                     6'($urandom), num, 1'($urandom));
    endtask

    initial begin
        int ph;
        stall_mode  = 0;
        stall_phase = 1;
        idle_cycles = 0;
        res.ready = 1'b1;
        req.valid = 1'b0;
        req.operation = OP_INIT;
        req.char_code = 8'h0;
        req.line_index = 2'd0;
        req.column_index = 6'd0;
        req.number = 32'd0;
        req.switch_on = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = REG_BUS8;
        cfg.data = 8'h0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: default settings, every operation and field extremes
        send_request(OP_INIT, 8'h0, 2'd0, 6'd0, 32'd0, 1'b0);
        send_request(OP_CHAR, 8'h00, 2'd0, 6'd0, 32'd0, 1'b0);
        send_request(OP_CHAR, 8'hFF, 2'd0, 6'd0, 32'd0, 1'b0);
        send_request(OP_POS, 8'h0, 2'd0, 6'd0, 32'd0, 1'b0);
        send_request(OP_POS, 8'h0, 2'd1, 6'd63, 32'd0, 1'b0);
        send_request(OP_POS, 8'h0, 2'd3, 6'd63, 32'd0, 1'b0);
        send_request(OP_CLEAR, 8'h0, 2'd0, 6'd0, 32'd0, 1'b0);
        send_request(OP_CLRHOM, 8'h0, 2'd0, 6'd0, 32'd0, 1'b0);
        send_request(OP_DEC, 8'h0, 2'd0, 6'd0, 32'd0, 1'b0);
        send_request(OP_DEC, 8'h0, 2'd0, 6'd0, 32'hFFFFFFFF, 1'b0);
        send_request(OP_DEC, 8'h0, 2'd0, 6'd0, 32'd1000000000, 1'b0);
        send_request(OP_DISP, 8'h0, 2'd0, 6'd0, 32'd0, 1'b0);
        send_request(OP_CURS, 8'h0, 2'd0, 6'd0, 32'd0, 1'b1);
        send_request(OP_BLINK, 8'h0, 2'd0, 6'd0, 32'd0, 1'b1);
        send_request(OP_BLINK, 8'h0, 2'd0, 6'd0, 32'd0, 1'b0);
        send_request(OP_BLIGHT, 8'h0, 2'd0, 6'd0, 32'd0, 1'b1);
        send_request(OP_BLIGHT, 8'h0, 2'd0, 6'd0, 32'd0, 1'b0);
        send_request(4'd15, 8'h0, 2'd0, 6'd0, 32'd0, 1'b1);
        stop_requests();
        settle();

        // phases with different settings, extremes included
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_BUS8, 8'd1);
                    write_reg(REG_LINES, 8'd4);
                    write_reg(REG_COLS, 8'd40);
                    write_reg(REG_BL_LOW, 8'd1);
                end
                1: begin
                    write_reg(REG_BUS8, 8'd0);
                    write_reg(REG_LINES, 8'd1);
                    write_reg(REG_COLS, 8'd8);
                end
                2: begin
                    write_reg(REG_LINES, 8'd3);
                    write_reg(REG_COLS, 8'($urandom_range(8, 40)));
                    write_reg(REG_BL_LOW, 8'd0);
                end
                default: begin
                    write_reg(REG_BUS8, 8'($urandom_range(0, 1)));
                    write_reg(REG_LINES, 8'($urandom_range(1, 4)));
                    write_reg(REG_COLS, 8'($urandom_range(8, 40)));
                    write_reg(REG_BL_LOW, 8'($urandom_range(0, 1)));
                end
            endcase
            stop_config();
            send_request(OP_INIT, 8'h0, 2'd0, 6'd0, 32'd0, 1'b0);
            send_request(OP_POS, 8'h0, 2'd2, 6'd63, 32'd0, 1'b0);
            send_request(OP_POS, 8'h0, 2'd3, 6'd63, 32'd0, 1'b0);
            send_request(OP_BLIGHT, 8'h0, 2'd0, 6'd0, 32'd0, 1'b1);
            repeat (24) random_request();
            stop_requests();
            settle();
        end

        if (errors == 0)
            $display("character_lcd_command_sequencer_test: done, clean");
        else
            $display("character_lcd_command_sequencer_test: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/lcdcs_pkg.sv
design/lcdcs_ifs.sv
design/lcdcs_div10.sv
design/character_lcd_command_sequencer.sv
design/lcdcs_chk.sv
dv/lcdcs_checker.sv
dv/character_lcd_command_sequencer_test.sv
